// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: the consequent holds in the cycle of the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication: the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/swom_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Oscillator mixer package
// Bank size, memory layout, state encoding and request codes.
// ---------------------------------------------------------------------------
package swom_pkg;

    // Number of oscillators in the bank.
    localparam int OSC_COUNT = 16;
    // Address width of the oscillator memory.
    localparam int ADDR_W    = (OSC_COUNT > 1) ? $clog2(OSC_COUNT) : 1;
    // Address of the last oscillator in the bank.
    localparam logic [ADDR_W-1:0] OSC_LAST = ADDR_W'(OSC_COUNT - 1);
    // Bank size as a 9-bit value, for the range check on set requests.
    localparam logic [8:0] IDX_LIMIT = 9'(OSC_COUNT);

    // Request action codes.
    localparam logic ACT_SET  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_STEREO = 1'b0;
    localparam logic CFG_STEP   = 1'b1;

    // One memory entry: level, half-period wrap and phase counter.
    typedef struct packed {
        logic signed [15:0] level;
        logic [31:0]        wrap;
        logic [31:0]        phase;
    } t_osc_entry;

    localparam int ENTRY_W = $bits(t_osc_entry);

    // Result of advancing one oscillator by one tick.
    typedef struct packed {
        logic               active;
        logic signed [15:0] level;
        logic [31:0]        phase;
    } t_osc_upd;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MIX
    } t_state;

endpackage

// ===== rtl/core/swom_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying set and tick requests into the mixer.
// ---------------------------------------------------------------------------
interface swom_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [3:0]         osc_index;
    logic signed [15:0] amplitude;
    logic [31:0]        wrap_count;

    modport source (output valid, action, osc_index, amplitude, wrap_count, input ready);
    modport sink   (input valid, action, osc_index, amplitude, wrap_count, output ready);
endinterface

// ===== rtl/core/swom_out_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying mixed samples out of the mixer.
// ---------------------------------------------------------------------------
interface swom_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               channel;
    logic               last_of_frame;

    modport source (output valid, sample, channel, last_of_frame, input ready);
    modport sink   (input valid, sample, channel, last_of_frame, output ready);
endinterface

// ===== rtl/core/swom_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module swom_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/swom_osc_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Oscillator step
// Advances one oscillator's phase by the step and flips its level on wrap.
// ---------------------------------------------------------------------------
module swom_osc_step (
    input  logic                  i_entry_vld,
    input  swom_pkg::t_osc_entry  i_entry,
    input  logic [31:0]           i_step,
    output swom_pkg::t_osc_upd    o_upd
);
    import swom_pkg::*;

    logic signed [15:0] level;
    logic [31:0]        phase_sum;
    logic               wrapped;

    // An entry never written reads as silent.
    assign level = i_entry_vld ? i_entry.level : 16'sd0;

    // Advance the phase modulo 2^32 and test against the wrap value.
    assign phase_sum = i_entry.phase + i_step;
    assign wrapped   = (phase_sum >= i_entry.wrap);

    // The most negative level negates to itself in 16 bits.
    always_comb begin
        o_upd.active = (level != 16'sd0);
        o_upd.phase  = wrapped ? (phase_sum - i_entry.wrap) : phase_sum;
        o_upd.level  = wrapped ? -level : level;
    end

endmodule

// ===== rtl/core/square_wave_oscillator_mixer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Square-wave oscillator mixer
// Bank of square-wave oscillators held in one RAM and mixed per tick.
// ---------------------------------------------------------------------------
// Usage:
// Requests arrive on i_req. A set request loads one oscillator's amplitude
// and wrap value and clears its phase; it gives no sample. A tick request
// scans the bank one oscillator per cycle through the one read port and one
// write port of the state RAM, then gives the mix as its first sample on o_res.
// In stereo mode a tick gives two samples, left then right; otherwise one.
// The last sample of a tick carries last_of_frame.
// Configuration (stereo mode, count step) is written through i_cfg_we; the
// user must write it only while the block is idle, which the block itself
// does not enforce. After reset every oscillator is silent, stereo mode is
// off and the step is one; per-entry valid bits stand in for clearing the RAM.
// When the receiver stalls, the output register holds the sample. In mono
// mode a new request is still taken, but a tick does not finish until the
// register frees; in stereo mode requests wait until the left sample has gone.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module square_wave_oscillator_mixer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    swom_in_if.sink     i_req,
    swom_out_if.source  o_res
);
    import swom_pkg::*;

    // Control and configuration registers.
    t_state                 r_state, n_state;
    logic                   r_stereo;
    logic [31:0]            r_step;
    logic [ADDR_W-1:0]      r_idx;
    logic                   r_vld1;
    logic [ADDR_W-1:0]      r_idx1;
    logic [OSC_COUNT-1:0]   r_osc_vld;
    logic signed [15:0]     r_sum;

    // Output register.
    logic                   r_out_vld;
    logic signed [15:0]     r_out_sample;
    logic                   r_out_chan;
    logic                   r_out_last;
    logic                   r_right_pend;

    // Datapath signals.
    logic                   in_ready;
    logic                   req_take;
    logic                   tick_take;
    logic                   set_take;
    logic                   out_take;
    logic                   mix_load;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    t_osc_entry             ram_wdata;
    t_osc_entry             ram_rdata;
    t_osc_upd               upd;
    logic signed [15:0]     mixed;

    assign req_take  = i_req.valid && in_ready;
    assign tick_take = req_take && (i_req.action == ACT_TICK);
    assign set_take  = req_take && (i_req.action == ACT_SET)
                       && ({5'b0, i_req.osc_index} < IDX_LIMIT);
    assign out_take  = r_out_vld && o_res.ready;
    assign mixed     = {r_sum[14:0], 1'b0};

    // Next-state logic of the scan sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (tick_take) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == OSC_LAST) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_MIX;
            end
            ST_MIX: begin
                if (!r_out_vld || out_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        in_ready = 1'b0;
        mix_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                in_ready = !r_right_pend;
            end
            ST_MIX: begin
                mix_load = !r_out_vld || out_take;
            end
            ST_SCAN, ST_DRAIN: begin
                in_ready = 1'b0;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Oscillator state memory.
    swom_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (OSC_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Per-oscillator update on the entry read in the previous cycle.
    swom_osc_step u_step (
        .i_entry_vld (r_osc_vld[r_idx1]),
        .i_entry     (ram_rdata),
        .i_step      (r_step),
        .o_upd       (upd)
    );

    // Write port: set requests when idle, write-back of active oscillators
    // during the scan. Reads run one entry ahead of writes, so they never meet.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx1;
        ram_wdata = '{level: upd.level, wrap: ram_rdata.wrap, phase: upd.phase};
        if (set_take) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(i_req.osc_index);
            ram_wdata = '{level: i_req.amplitude, wrap: i_req.wrap_count, phase: 32'd0};
        end else if (r_vld1 && upd.active) begin
            ram_we    = 1'b1;
        end
    end

    // Sequencer, configuration and valid-bit registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_stereo  <= 1'b0;
            r_step    <= 32'd1;
            r_idx     <= '0;
            r_vld1    <= 1'b0;
            r_osc_vld <= '0;
        end else begin
            r_state <= n_state;
            r_vld1  <= (r_state == ST_SCAN);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_STEREO: r_stereo <= i_cfg_data[0];
                    CFG_STEP:   r_step   <= i_cfg_data;
                    default:    r_step   <= r_step;
                endcase
            end
            if (tick_take) begin
                r_idx <= '0;
            end else if (r_state == ST_SCAN) begin
                r_idx <= r_idx + 1'b1;
            end
            if (set_take) begin
                r_osc_vld[ADDR_W'(i_req.osc_index)] <= 1'b1;
            end
        end
    end

    // Pipeline address and running sum of the mix.
    always_ff @(posedge i_clk) begin
        r_idx1 <= r_idx;
        if (tick_take) begin
            r_sum <= 16'sd0;
        end else if (r_vld1 && upd.active) begin
            r_sum <= r_sum + upd.level;
        end
    end

    // Output register with a pending right-channel sample in stereo mode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld    <= 1'b0;
            r_right_pend <= 1'b0;
        end else begin
            priority if (mix_load) begin
                r_out_vld    <= 1'b1;
                r_out_sample <= mixed;
                r_out_chan   <= 1'b0;
                r_out_last   <= !r_stereo;
                r_right_pend <= r_stereo;
            end else if (r_right_pend && out_take) begin
                r_out_vld    <= 1'b1;
                r_out_chan   <= 1'b1;
                r_out_last   <= 1'b1;
                r_right_pend <= 1'b0;
            end else if (out_take) begin
                r_out_vld    <= 1'b0;
            end else begin
                r_out_vld    <= r_out_vld;
            end
        end
    end

    assign i_req.ready         = in_ready;
    assign o_res.valid         = r_out_vld;
    assign o_res.sample        = r_out_sample;
    assign o_res.channel       = r_out_chan;
    assign o_res.last_of_frame = r_out_last;

    // Checks on the sequencer and output register.
    `ASSERT_NEXT(a_tick_starts_scan, tick_take, r_state == ST_SCAN)
    `ASSERT_IMPL(a_right_needs_left, r_right_pend, r_out_vld && !r_out_chan)
    `ASSERT_IMPL(a_scan_write_piped, ram_we && (r_state != ST_IDLE), r_vld1)
    `ASSERT_IMPL(a_right_is_last, r_out_vld && r_out_chan, r_out_last)

endmodule
